// File: rtl/kcd_pkg.sv
`timescale 1ns / 1ps

package kcd_pkg;

  localparam int unsigned TIMER_WIDTH = 16;
  localparam int unsigned DELAY_WIDTH = 16;
  localparam int unsigned CFG_IDX_WIDTH = 3;

  localparam logic [32:0] TIMER_MAX = (33'(1) << TIMER_WIDTH) - 33'(1);

  localparam logic [DELAY_WIDTH-1:0] LONG_DELAY_RESET = DELAY_WIDTH'(300);
  localparam logic [DELAY_WIDTH-1:0] MULTI_DELAY_RESET = DELAY_WIDTH'(30);

  typedef enum logic {
    OP_KEY  = 1'b0,
    OP_TICK = 1'b1
  } kcd_op_e;

  typedef enum logic [1:0] {
    KIND_STATE = 2'd0,
    KIND_COUNT = 2'd1,
    KIND_LONG  = 2'd2
  } kcd_kind_e;

  typedef enum logic [CFG_IDX_WIDTH-1:0] {
    REG_CLICK_EN       = 3'd0,
    REG_LONG_CLICK_EN  = 3'd1,
    REG_MULTI_CLICK_EN = 3'd2,
    REG_LONG_DELAY     = 3'd3,
    REG_MULTI_DELAY    = 3'd4
  } kcd_reg_e;

  typedef struct packed {
    logic                   click_en;
    logic                   long_click_en;
    logic                   multi_click_en;
    logic [DELAY_WIDTH-1:0] long_delay;
    logic [DELAY_WIDTH-1:0] multi_delay;
  } kcd_cfg_t;

  typedef struct packed {
    kcd_kind_e  kind;
    logic [7:0] code;
    logic [7:0] value;
  } kcd_result_t;

  typedef struct packed {
    logic long_armed;
    logic window_armed;
  } kcd_status_t;

  // A delay of zero behaves as one, and the delay is clipped to the timer range.
  function automatic logic [TIMER_WIDTH-1:0] load_delay(input logic [DELAY_WIDTH-1:0] d);
    logic [32:0] ext;
    ext = 33'(d);
    if (d == '0) begin
      ext = 33'(1);
    end
    if (ext > TIMER_MAX) begin
      ext = TIMER_MAX;
    end
    return ext[TIMER_WIDTH-1:0];
  endfunction

endpackage

// File: rtl/kcd_core.sv
`timescale 1ns / 1ps

module kcd_core import kcd_pkg::*; (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        accept_i,
  input  logic        operation_i,
  input  logic [7:0]  key_code_i,
  input  logic [7:0]  key_value_i,
  input  kcd_cfg_t    cfg_i,
  output logic        res_valid_o,
  output kcd_result_t res_o,
  output kcd_status_t status_o
);

  logic [7:0]             last_code_q, last_code_d;
  logic [7:0]             count_q, count_d;
  logic [TIMER_WIDTH-1:0] long_timer_q, long_timer_d;
  logic                   long_armed_q, long_armed_d;
  logic [TIMER_WIDTH-1:0] window_timer_q, window_timer_d;
  logic                   window_armed_q, window_armed_d;

  always_comb begin
    last_code_d    = last_code_q;
    count_d        = count_q;
    long_timer_d   = long_timer_q;
    long_armed_d   = long_armed_q;
    window_timer_d = window_timer_q;
    window_armed_d = window_armed_q;
    res_valid_o    = 1'b0;
    res_o.kind     = KIND_STATE;
    res_o.code     = key_code_i;
    res_o.value    = key_value_i;

    if (accept_i) begin
      if (operation_i == OP_TICK) begin
        if (long_armed_q) begin
          if (long_timer_q <= TIMER_WIDTH'(1)) begin
            long_timer_d = '0;
            long_armed_d = 1'b0;
            count_d      = '0;
            res_valid_o  = 1'b1;
            res_o.kind   = KIND_LONG;
            res_o.code   = last_code_q;
            res_o.value  = '0;
          end else begin
            long_timer_d = long_timer_q - TIMER_WIDTH'(1);
          end
        end else if (window_armed_q) begin
          if (window_timer_q <= TIMER_WIDTH'(1)) begin
            window_timer_d = '0;
            window_armed_d = 1'b0;
            count_d        = '0;
            res_valid_o    = (count_q != '0);
            res_o.kind     = KIND_COUNT;
            res_o.code     = last_code_q;
            res_o.value    = count_q;
          end else begin
            window_timer_d = window_timer_q - TIMER_WIDTH'(1);
          end
        end
      end else if (cfg_i.long_click_en || cfg_i.multi_click_en) begin
        long_armed_d   = 1'b0;
        window_armed_d = 1'b0;
        if (key_value_i != '0) begin
          if (key_code_i == last_code_q) begin
            if (count_q != 8'hFF) begin
              count_d = count_q + 8'd1;
            end
          end else begin
            last_code_d = key_code_i;
            count_d     = 8'd1;
          end
          long_timer_d = load_delay(cfg_i.long_delay);
          long_armed_d = 1'b1;
        end else if (cfg_i.multi_click_en) begin
          window_timer_d = load_delay(cfg_i.multi_delay);
          window_armed_d = 1'b1;
        end else begin
          count_d     = '0;
          res_valid_o = (count_q != '0);
          res_o.kind  = KIND_COUNT;
          res_o.value = count_q;
        end
      end else if (cfg_i.click_en) begin
        if (key_value_i != '0) begin
          count_d     = '0;
          res_valid_o = 1'b1;
          res_o.kind  = KIND_COUNT;
          res_o.value = 8'd1;
        end
      end else begin
        res_valid_o = 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      last_code_q    <= '0;
      count_q        <= '0;
      long_timer_q   <= '0;
      long_armed_q   <= 1'b0;
      window_timer_q <= '0;
      window_armed_q <= 1'b0;
    end else begin
      last_code_q    <= last_code_d;
      count_q        <= count_d;
      long_timer_q   <= long_timer_d;
      long_armed_q   <= long_armed_d;
      window_timer_q <= window_timer_d;
      window_armed_q <= window_armed_d;
    end
  end

  assign status_o.long_armed   = long_armed_q;
  assign status_o.window_armed = window_armed_q;

endmodule

// File: rtl/key_click_detector_unit.sv
`timescale 1ns / 1ps
// Results are registered. Throughput: one input transaction per cycle while the
// skid register is empty; a two-entry output stage (output register plus skid
// register) lets input continue while one result waits. Reset clears the
// detector state and the output stage and returns the configuration registers
// to their reset values.

module key_click_detector_unit import kcd_pkg::*; (
  input  logic                     clk_i,
  input  logic                     rst_ni,
  input  logic                     in_valid_i,
  output logic                     in_ready_o,
  input  logic                     operation_i,
  input  logic [7:0]               key_code_i,
  input  logic [7:0]               key_value_i,
  output logic                     out_valid_o,
  input  logic                     out_ready_i,
  output logic [1:0]               event_kind_o,
  output logic [7:0]               event_code_o,
  output logic [7:0]               event_value_o,
  input  logic                     cfg_valid_i,
  output logic                     cfg_ready_o,
  input  logic [CFG_IDX_WIDTH-1:0] cfg_index_i,
  input  logic [DELAY_WIDTH-1:0]   cfg_data_i
);

  kcd_cfg_t    cfg_q;
  kcd_result_t res;
  logic        res_valid;
  kcd_status_t status;
  logic        accept;

  kcd_result_t out_q, skid_q;
  logic        out_valid_q, out_valid_d;
  logic        skid_valid_q, skid_valid_d;
  logic        push, pop;

  assign cfg_ready_o = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.click_en       <= 1'b0;
      cfg_q.long_click_en  <= 1'b0;
      cfg_q.multi_click_en <= 1'b0;
      cfg_q.long_delay     <= LONG_DELAY_RESET;
      cfg_q.multi_delay    <= MULTI_DELAY_RESET;
    end else if (cfg_valid_i) begin
      unique case (cfg_index_i)
        REG_CLICK_EN:       cfg_q.click_en       <= cfg_data_i[0];
        REG_LONG_CLICK_EN:  cfg_q.long_click_en  <= cfg_data_i[0];
        REG_MULTI_CLICK_EN: cfg_q.multi_click_en <= cfg_data_i[0];
        REG_LONG_DELAY:     cfg_q.long_delay     <= cfg_data_i;
        REG_MULTI_DELAY:    cfg_q.multi_delay    <= cfg_data_i;
        default: begin
        end
      endcase
    end
  end

  assign in_ready_o = !skid_valid_q;
  assign accept     = in_valid_i && in_ready_o;

  kcd_core u_core (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .accept_i    (accept),
    .operation_i (operation_i),
    .key_code_i  (key_code_i),
    .key_value_i (key_value_i),
    .cfg_i       (cfg_q),
    .res_valid_o (res_valid),
    .res_o       (res),
    .status_o    (status)
  );

  assign push = res_valid;
  assign pop  = out_valid_q && out_ready_i;

  always_comb begin
    out_valid_d  = out_valid_q;
    skid_valid_d = skid_valid_q;
    if (skid_valid_q) begin
      if (pop) begin
        skid_valid_d = 1'b0;
      end
    end else if (push) begin
      if (out_valid_q && !pop) begin
        skid_valid_d = 1'b1;
      end else begin
        out_valid_d = 1'b1;
      end
    end else if (pop) begin
      out_valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q  <= 1'b0;
      skid_valid_q <= 1'b0;
    end else begin
      out_valid_q  <= out_valid_d;
      skid_valid_q <= skid_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (skid_valid_q) begin
      if (pop) begin
        out_q <= skid_q;
      end
    end else if (push) begin
      if (out_valid_q && !pop) begin
        skid_q <= res;
      end else begin
        out_q <= res;
      end
    end
  end

  assign out_valid_o   = out_valid_q;
  assign event_kind_o  = out_q.kind;
  assign event_code_o  = out_q.code;
  assign event_value_o = out_q.value;

`ifndef SYNTH
  // The skid register only fills behind an occupied output register.
  a_skid_behind_out: assert property (@(posedge clk_i) disable iff (!rst_ni)
    skid_valid_q |-> out_valid_q)
    else $error("skid entry held while output register is empty");

  // A skid entry never leaves the output stage empty in the following cycle.
  a_skid_drains_to_out: assert property (@(posedge clk_i) disable iff (!rst_ni)
    skid_valid_q |=> out_valid_q)
    else $error("output register empty after skid entry");

  // A key transaction arms at most one timer and ticks only disarm.
  a_one_timer_armed: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !(status.long_armed && status.window_armed))
    else $error("both timers armed");
`endif

endmodule

// File: bench/key_click_detector_unit_tb.sv
`timescale 1ns / 1ps

module key_click_detector_unit_tb;
  import kcd_pkg::*;

  localparam int IDLE_LIMIT  = 2000;
  localparam int HOLD_CYCLES = 300;
  localparam int ITEM_TARGET = 1400;
  localparam int SETTLE      = 4;

  class click_scoreboard;
    bit                   click_en;
    bit                   long_en;
    bit                   multi_en;
    bit [15:0]            long_delay;
    bit [15:0]            multi_delay;
    bit [7:0]             last_code;
    bit [7:0]             click_count;
    bit [TIMER_WIDTH-1:0] long_timer;
    bit [TIMER_WIDTH-1:0] window_timer;
    bit                   long_armed;
    bit                   window_armed;
    kcd_result_t          pending_events[$];
    int                   errors;
    int                   n_results;
    int                   n_by_kind[3];

    function new();
      long_delay  = 16'd300;
      multi_delay = 16'd30;
    endfunction

    function void write_reg(logic [CFG_IDX_WIDTH-1:0] idx, logic [15:0] data);
      case (idx)
        REG_CLICK_EN:       click_en = data[0];
        REG_LONG_CLICK_EN:  long_en = data[0];
        REG_MULTI_CLICK_EN: multi_en = data[0];
        REG_LONG_DELAY:     long_delay = data;
        REG_MULTI_DELAY:    multi_delay = data;
        default: ;
      endcase
    endfunction

    function bit [TIMER_WIDTH-1:0] timer_load(bit [15:0] d);
      bit [32:0] span;
      bit [32:0] top;
      top = (33'(1) << TIMER_WIDTH) - 33'(1);
      span = (d == 16'd0) ? 33'(1) : 33'(d);
      if (span > top) begin
        span = top;
      end
      return span[TIMER_WIDTH-1:0];
    endfunction

    function void add_event(kcd_kind_e kind, bit [7:0] code, bit [7:0] value);
      kcd_result_t r;
      r.kind  = kind;
      r.code  = code;
      r.value = value;
      pending_events.push_back(r);
    endfunction

    function void report_clicks(bit [7:0] code, bit [7:0] count);
      click_count = 8'd0;
      if (count != 8'd0) begin
        add_event(KIND_COUNT, code, count);
      end
    endfunction

    function void note_input(bit op, bit [7:0] code, bit [7:0] value);
      if (op == OP_TICK) begin
        if (long_armed) begin
          if (long_timer <= 1) begin
            long_timer  = '0;
            long_armed  = 1'b0;
            click_count = 8'd0;
            add_event(KIND_LONG, last_code, 8'd0);
          end else begin
            long_timer--;
          end
        end else if (window_armed) begin
          if (window_timer <= 1) begin
            window_timer = '0;
            window_armed = 1'b0;
            report_clicks(last_code, click_count);
          end else begin
            window_timer--;
          end
        end
        return;
      end
      if (long_en || multi_en) begin
        long_armed   = 1'b0;
        window_armed = 1'b0;
        if (value != 8'd0) begin
          if (code == last_code) begin
            if (click_count != 8'hFF) begin
              click_count++;
            end
          end else begin
            last_code   = code;
            click_count = 8'd1;
          end
          long_timer = timer_load(long_delay);
          long_armed = 1'b1;
        end else if (multi_en) begin
          window_timer = timer_load(multi_delay);
          window_armed = 1'b1;
        end else begin
          report_clicks(code, click_count);
        end
      end else if (click_en) begin
        if (value != 8'd0) begin
          report_clicks(code, 8'd1);
        end
      end else begin
        add_event(KIND_STATE, code, value);
      end
    endfunction

    function void check_result(logic [1:0] kind, logic [7:0] code, logic [7:0] value);
      kcd_result_t want;
      if (pending_events.size() == 0) begin
        errors++;
        if (errors <= 10) begin
          $display("Unexpected result: kind=%0d code=%0d value=%0d", kind, code, value);
        end
        return;
      end
      want = pending_events.pop_front();
      n_results++;
      n_by_kind[want.kind]++;
      if (kind !== want.kind || code !== want.code || value !== want.value) begin
        errors++;
        if (errors <= 10) begin
          $display("Mismatch: expected kind=%0d code=%0d value=%0d, got kind=%0d code=%0d value=%0d",
                   want.kind, want.code, want.value, kind, code, value);
        end
      end
    endfunction
  endclass

  logic                     clk_i;
  logic                     rst_ni = 1'b0;
  logic                     in_valid_i = 1'b0;
  logic                     in_ready_o;
  logic                     operation_i = 1'b0;
  logic [7:0]               key_code_i = 8'd0;
  logic [7:0]               key_value_i = 8'd0;
  logic                     out_valid_o;
  logic                     out_ready_i = 1'b0;
  logic [1:0]               event_kind_o;
  logic [7:0]               event_code_o;
  logic [7:0]               event_value_o;
  logic                     cfg_valid_i = 1'b0;
  logic                     cfg_ready_o;
  logic [CFG_IDX_WIDTH-1:0] cfg_index_i = '0;
  logic [DELAY_WIDTH-1:0]   cfg_data_i = '0;

  logic hold_req = 1'b0;
  logic no_idle = 1'b0;

  click_scoreboard sb = new();
  int items_sent = 0;
  int n_writes = 0;
  int n_settings = 0;

  key_click_detector_unit i_dut (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .in_valid_i   (in_valid_i),
    .in_ready_o   (in_ready_o),
    .operation_i  (operation_i),
    .key_code_i   (key_code_i),
    .key_value_i  (key_value_i),
    .out_valid_o  (out_valid_o),
    .out_ready_i  (out_ready_i),
    .event_kind_o (event_kind_o),
    .event_code_o (event_code_o),
    .event_value_o(event_value_o),
    .cfg_valid_i  (cfg_valid_i),
    .cfg_ready_o  (cfg_ready_o),
    .cfg_index_i  (cfg_index_i),
    .cfg_data_i   (cfg_data_i)
  );

  always begin
    clk_i = 1'b0;
    #1;
    clk_i = 1'b1;
    #1;
  end

  function automatic int pick_gap();
    int r;
    r = $urandom_range(0, 99);
    if (r < 60) begin
      return 0;
    end else if (r < 92) begin
      return $urandom_range(1, 3);
    end
    return $urandom_range(10, 40);
  endfunction

  function automatic logic [15:0] pick_delay();
    int r;
    r = $urandom_range(0, 9);
    if (r == 0) begin
      return 16'd0;
    end else if (r == 1) begin
      return 16'hFFFF;
    end else if (r == 2) begin
      return 16'($urandom());
    end
    return 16'($urandom_range(1, 6));
  endfunction

  task automatic send_item(kcd_op_e op, logic [7:0] code, logic [7:0] value);
    int gap;
    gap = no_idle ? 0 : pick_gap();
    if (gap > 0) begin
      in_valid_i <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    in_valid_i  <= 1'b1;
    operation_i <= op;
    key_code_i  <= code;
    key_value_i <= value;
    do @(posedge clk_i); while (!(in_valid_i && in_ready_o));
    sb.note_input(operation_i, key_code_i, key_value_i);
    items_sent++;
  endtask

  task automatic key(logic [7:0] code, logic [7:0] value);
    send_item(OP_KEY, code, value);
  endtask

  task automatic ticks(int n);
    repeat (n) send_item(OP_TICK, 8'($urandom()), 8'($urandom()));
  endtask

  task automatic drain();
    in_valid_i <= 1'b0;
    while (sb.pending_events.size() != 0) @(posedge clk_i);
    repeat (SETTLE) @(posedge clk_i);
  endtask

  task automatic cfg_write(logic [CFG_IDX_WIDTH-1:0] idx, logic [15:0] data);
    cfg_valid_i <= 1'b1;
    cfg_index_i <= idx;
    cfg_data_i  <= data;
    do @(posedge clk_i); while (!(cfg_valid_i && cfg_ready_o));
    sb.write_reg(idx, data);
    n_writes++;
  endtask

  task automatic configure(bit click, bit lng, bit multi, logic [15:0] ld, logic [15:0] md);
    drain();
    cfg_write(REG_CLICK_EN, (16'($urandom()) & 16'hFFFE) | 16'(click));
    cfg_write(REG_LONG_CLICK_EN, (16'($urandom()) & 16'hFFFE) | 16'(lng));
    cfg_write(REG_MULTI_CLICK_EN, (16'($urandom()) & 16'hFFFE) | 16'(multi));
    cfg_write(REG_LONG_DELAY, ld);
    cfg_write(REG_MULTI_DELAY, md);
    if ($urandom_range(0, 3) == 0) begin
      cfg_write(CFG_IDX_WIDTH'($urandom_range(5, 7)), 16'($urandom()));
    end
    cfg_valid_i <= 1'b0;
    n_settings++;
  endtask

  // Result side: checks every transaction and stalls at random, with one long hold-off.
  initial begin
    int stall_left;
    bit hold_done;
    stall_left = 0;
    hold_done  = 1'b0;
    forever begin
      @(posedge clk_i);
      if (rst_ni && out_valid_o && out_ready_i) begin
        sb.check_result(event_kind_o, event_code_o, event_value_o);
      end
      if (hold_req && !hold_done) begin
        hold_done  = 1'b1;
        stall_left = HOLD_CYCLES;
      end else if (stall_left == 0 && !no_idle && $urandom_range(0, 3) == 0) begin
        stall_left = pick_gap();
      end
      if (stall_left > 0) begin
        out_ready_i <= 1'b0;
        stall_left--;
      end else begin
        out_ready_i <= 1'b1;
      end
    end
  end

  initial begin
    int idle;
    idle = 0;
    while (idle < IDLE_LIMIT) begin
      @(posedge clk_i);
      if ((in_valid_i && in_ready_o) || (out_valid_o && out_ready_i) ||
          (cfg_valid_i && cfg_ready_o)) begin
        idle = 0;
      end else begin
        idle++;
      end
    end
    $display("No transaction for %0d cycles.", IDLE_LIMIT);
    $display("FAIL key_click_detector_unit");
    $finish;
  end

  initial begin
    int          phase;
    int          mode;
    int          lim_l;
    int          lim_m;
    int          presses;
    logic [15:0] ld;
    logic [15:0] md;
    logic [7:0]  pool[3];
    logic [7:0]  code;

    repeat (6) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // Reset settings: raw key state passes through, ticks are ignored.
    key(8'd0, 8'd0);
    key(8'hFF, 8'hFF);
    key(8'hA5, 8'h5A);
    ticks(1);

    configure(1'b1, 1'b0, 1'b0, 16'd300, 16'd30);
    key(8'd7, 8'd1);
    key(8'd7, 8'd0);
    key(8'hFF, 8'hFF);

    configure(1'b0, 1'b1, 1'b0, 16'd2, 16'd30);
    key(8'd5, 8'd9);
    ticks(2);
    key(8'd5, 8'd1);
    key(8'd5, 8'd1);
    key(8'd5, 8'd0);

    // Multi only: a press still arms the long-press timer; zero delay acts as one.
    configure(1'b0, 1'b0, 1'b1, 16'd1, 16'd0);
    key(8'd9, 8'd3);
    key(8'd9, 8'd0);
    ticks(1);
    key(8'd9, 8'd0);
    ticks(2);
    key(8'd9, 8'd4);
    ticks(1);

    configure(1'b1, 1'b1, 1'b1, 16'd3, 16'd2);
    key(8'd1, 8'd1);
    key(8'd2, 8'd2);
    key(8'd2, 8'd0);
    ticks(2);

    phase = 0;
    while (items_sent < ITEM_TARGET) begin
      phase++;
      mode = $urandom_range(0, 7);
      ld = pick_delay();
      md = pick_delay();
      if (phase == 1) begin
        mode = 7;
        ld   = 16'd0;
        md   = 16'd0;
      end
      if (phase == 2) begin
        configure(1'b0, 1'b0, 1'b0, 16'hFFFF, 16'hFFFF);
        no_idle  <= 1'b1;
        hold_req <= 1'b1;
        repeat (40) key(8'($urandom()), 8'($urandom()));
        drain();
        no_idle <= 1'b0;
        continue;
      end
      if (phase == 4) begin
        // Enough presses of one key to saturate the click count.
        configure(1'b0, 1'b1, 1'b0, 16'hFFFF, md);
        code = 8'($urandom());
        repeat (260) key(code, 8'($urandom_range(1, 255)));
        key(code, 8'd0);
        ticks(2);
        continue;
      end
      configure(mode[0], mode[1], mode[2], ld, md);
      no_idle <= ($urandom_range(0, 4) == 0);
      foreach (pool[i]) pool[i] = 8'($urandom());
      lim_l = (ld == 16'd0) ? 1 : ((ld < 16'd8) ? int'(ld) : 3);
      lim_m = (md == 16'd0) ? 1 : ((md < 16'd8) ? int'(md) : 3);
      repeat ($urandom_range(12, 25)) begin
        if ($urandom_range(0, 3) != 0) begin
          code = pool[$urandom_range(0, 2)];
          presses = $urandom_range(1, 4);
          for (int p = 0; p < presses; p++) begin
            key(code, 8'($urandom_range(1, 255)));
            ticks($urandom_range(0, lim_l + 1));
            key(code, 8'd0);
            if (p < presses - 1) begin
              ticks($urandom_range(0, lim_m - 1));
            end else begin
              ticks($urandom_range(lim_m, lim_m + 2));
            end
          end
        end else begin
          send_item($urandom_range(0, 1) ? OP_TICK : OP_KEY, 8'($urandom()),
                    ($urandom_range(0, 3) == 0) ? 8'd0 : 8'($urandom()));
        end
      end
    end

    drain();
    if (sb.pending_events.size() != 0) begin
      $display("%0d expected results never arrived.", sb.pending_events.size());
      sb.errors += sb.pending_events.size();
    end
    $display("Run covered %0d input transactions and %0d results over %0d settings (%0d writes).",
             items_sent, sb.n_results, n_settings, n_writes);
    $display("Results by kind: %0d raw state, %0d click count, %0d long click; %0d errors.",
             sb.n_by_kind[KIND_STATE], sb.n_by_kind[KIND_COUNT], sb.n_by_kind[KIND_LONG],
             sb.errors);
    if (sb.errors == 0) begin
      $display("PASS key_click_detector_unit");
    end else begin
      $display("FAIL key_click_detector_unit");
    end
    $finish;
  end

endmodule
